### rtl/lcp_array_from_suffix_array_assert.svh
// Assertion macros for the LCP array builder.
// LCPA_ASSERT is disabled while reset is low; LCPA_ASSERT_ALWAYS is checked at every edge.
`ifndef LCP_ARRAY_FROM_SUFFIX_ARRAY_ASSERT_SVH
`define LCP_ARRAY_FROM_SUFFIX_ARRAY_ASSERT_SVH
`ifndef SYNTHESIS
`define LCPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCPA_ASSERT(label, clk, rst_n, prop, msg)
`define LCPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/lcpa_pkg.sv
package lcpa_pkg;

    localparam int SYM_IN_W  = 16;
    localparam int SUF_W     = 10;
    localparam int RANK_IN_W = 10;
    localparam int LCP_W     = 10;

    localparam logic [LCP_W-1:0] LCP_MAX = '1;

    // command field codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;       // accepted load word
        logic read;       // accepted read word
        logic out_load;   // move read answer into output register
        logic p_rst;      // restart position counter and match length
        logic clr_step;   // zero rank/lcp entry at p
        logic rank_step;  // rank pass: read suffix at p, write rank of previous
        logic rank_rd;    // sweep: read rank of p
        logic skip;       // sweep: p has last rank, k <= 0
        logic q_rd;       // sweep: read suffix at rank+1
        logic t_rd;       // sweep: read text at p+k and q+k
        logic k_inc;      // sweep: symbols matched
        logic lcp_wr;     // sweep: store lcp of rank, step p
        logic fin_wr;     // zero lcp entry at last rank
    } lcpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic last_pos;
        logic rank_done;
        logic skip;
        logic in_bounds;
        logic match;
    } lcpa_stat_t;

endpackage

### rtl/lcpa_if.sv
interface lcpa_req_if;
    import lcpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [SYM_IN_W-1:0]  symbol;
    logic [SUF_W-1:0]     suffix_start;
    logic                 last;
    logic [RANK_IN_W-1:0] read_rank;

    modport source (output valid, command, symbol, suffix_start, last, read_rank,
                    input ready);
    modport sink   (input valid, command, symbol, suffix_start, last, read_rank,
                    output ready);
endinterface

interface lcpa_rsp_if;
    import lcpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RANK_IN_W-1:0] rank_index;
    logic [LCP_W-1:0]     lcp_length;
    logic                 valid_res;

    modport source (output valid, rank_index, lcp_length, valid_res, input ready);
    modport sink   (input valid, rank_index, lcp_length, valid_res, output ready);
endinterface

### rtl/lcpa_ctrl.sv
`include "lcp_array_from_suffix_array_assert.svh"

module lcpa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    input  logic                  command,
    input  logic                  last,
    output logic                  ready,
    input  lcpa_pkg::lcpa_stat_t  stat,
    output lcpa_pkg::lcpa_cmd_t   cmd
);
    import lcpa_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_READ     = 10'b00_0000_0010,
        S_CLEAR    = 10'b00_0000_0100,
        S_RANK     = 10'b00_0000_1000,
        S_SW_RANK  = 10'b00_0001_0000,
        S_SW_NEXT  = 10'b00_0010_0000,
        S_SW_ISSUE = 10'b00_0100_0000,
        S_SW_CMP   = 10'b00_1000_0000,
        S_SW_WRITE = 10'b01_0000_0000,
        S_FINAL    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    if (command == CMD_READ)
                    begin
                        cmd.read   = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (last)
                        begin
                            cmd.p_rst  = 1'b1;
                            state_next = S_CLEAR;
                        end
                    end
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.last_pos)
                begin
                    cmd.p_rst  = 1'b1;
                    state_next = S_RANK;
                end
            end
            S_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (stat.rank_done)
                begin
                    cmd.p_rst  = 1'b1;
                    state_next = S_SW_RANK;
                end
            end
            S_SW_RANK:
            begin
                cmd.rank_rd = 1'b1;
                state_next  = S_SW_NEXT;
            end
            S_SW_NEXT:
            begin
                if (stat.skip)
                begin
                    cmd.skip   = 1'b1;
                    state_next = stat.last_pos ? S_FINAL : S_SW_RANK;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_SW_ISSUE;
                end
            end
            S_SW_ISSUE:
            begin
                cmd.t_rd   = 1'b1;
                state_next = stat.in_bounds ? S_SW_CMP : S_SW_WRITE;
            end
            S_SW_CMP:
            begin
                if (stat.match)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_SW_ISSUE;
                end
                else
                begin
                    state_next = S_SW_WRITE;
                end
            end
            S_SW_WRITE:
            begin
                cmd.lcp_wr = 1'b1;
                state_next = stat.last_pos ? S_FINAL : S_SW_RANK;
            end
            S_FINAL:
            begin
                cmd.fin_wr = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LCPA_ASSERT(a_close_starts_clear, clk, rst_n, (valid && ready && command == CMD_LOAD && last |=> state_reg == S_CLEAR), "closing load did not start the clearing pass")
    `LCPA_ASSERT(a_final_reopens, clk, rst_n, (state_reg == S_FINAL |=> state_reg == S_IDLE && ready), "build end did not reopen input")
    `LCPA_ASSERT(a_busy_blocks_input, clk, rst_n, (state_reg != S_IDLE |-> !ready), "input ready while busy")

endmodule

### rtl/lcpa_dp.sv
`include "lcp_array_from_suffix_array_assert.svh"

module lcpa_dp #(
    parameter int MAX_LEN     = 1024,
    parameter int SYMBOL_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lcpa_pkg::lcpa_cmd_t              cmd,
    output lcpa_pkg::lcpa_stat_t             stat,
    input  logic [lcpa_pkg::SYM_IN_W-1:0]    symbol,
    input  logic [lcpa_pkg::SUF_W-1:0]       suffix_start,
    input  logic                             last,
    input  logic [lcpa_pkg::RANK_IN_W-1:0]   read_rank,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [lcpa_pkg::RANK_IN_W-1:0]   rank_index,
    output logic [lcpa_pkg::LCP_W-1:0]       lcp_length,
    output logic                             valid_res
);
    import lcpa_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int WW = (LW > RANK_IN_W) ? LW : RANK_IN_W;
    localparam int SW = WW + 1;

    // storage
    logic [SYMBOL_BITS-1:0] text_mem [MAX_LEN];
    logic [SUF_W-1:0]       suf_mem  [MAX_LEN];
    logic [AW-1:0]          rank_mem [MAX_LEN];
    logic [LCP_W-1:0]       lcp_mem  [MAX_LEN];

    // control
    logic [LW-1:0] len_reg, len_next;
    logic          closed_reg, closed_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] k_reg, k_next;
    logic          pv_reg;
    logic          out_valid_reg, out_valid_next;

    // payload
    logic [AW-1:0]          pd_reg;
    logic [SUF_W-1:0]       suf_rd_reg;
    logic [AW-1:0]          rank_rd_reg;
    logic [LCP_W-1:0]       lcp_rd_reg;
    logic [SYMBOL_BITS-1:0] ta_reg;
    logic [SYMBOL_BITS-1:0] tb_reg;
    logic [RANK_IN_W-1:0]   rr_reg;
    logic                   hit_reg;
    logic [RANK_IN_W-1:0]   out_rank_reg;
    logic [LCP_W-1:0]       out_lcp_reg;
    logic                   out_vres_reg;

    logic [LW-1:0]    base;
    logic             room;
    logic             text_we;
    logic             p_lt_n;
    logic [LW-1:0]    r1;
    logic [SW-1:0]    pk;
    logic [SW-1:0]    qk;
    logic             suf_re;
    logic [AW-1:0]    suf_raddr;
    logic             s_in;
    logic             rank_we;
    logic [AW-1:0]    rank_waddr;
    logic [AW-1:0]    rank_wdata;
    logic             lcp_we;
    logic [AW-1:0]    lcp_waddr;
    logic [LCP_W-1:0] lcp_wdata;
    logic [LCP_W-1:0] k_sat;

    // a load after a closed set starts a new string
    assign base    = closed_reg ? '0 : len_reg;
    assign room    = base < LW'(MAX_LEN);
    assign text_we = cmd.load && room;

    assign p_lt_n = p_reg < len_reg;
    assign r1     = LW'(rank_rd_reg) + LW'(1);
    assign pk     = SW'(p_reg) + SW'(k_reg);
    assign qk     = SW'(suf_rd_reg) + SW'(k_reg);
    assign k_sat  = (WW'(k_reg) > WW'(LCP_MAX)) ? LCP_MAX : LCP_W'(k_reg);

    assign suf_re    = (cmd.rank_step && p_lt_n) || cmd.q_rd;
    assign suf_raddr = cmd.q_rd ? AW'(r1) : AW'(p_reg);

    // neighbor entries at or past the length are dropped from the rank pass
    assign s_in       = WW'(suf_rd_reg) < WW'(len_reg);
    assign rank_we    = cmd.clr_step || (pv_reg && s_in);
    assign rank_waddr = cmd.clr_step ? AW'(p_reg) : AW'(suf_rd_reg);
    assign rank_wdata = cmd.clr_step ? '0 : pd_reg;

    always_comb
    begin
        lcp_we    = 1'b0;
        lcp_waddr = AW'(p_reg);
        lcp_wdata = '0;
        priority if (cmd.clr_step)
        begin
            lcp_we = 1'b1;
        end
        else if (cmd.lcp_wr)
        begin
            lcp_we    = 1'b1;
            lcp_waddr = rank_rd_reg;
            lcp_wdata = k_sat;
        end
        else if (cmd.fin_wr)
        begin
            lcp_we    = 1'b1;
            lcp_waddr = AW'(len_reg - LW'(1));
        end
    end

    always_comb
    begin
        len_next    = len_reg;
        closed_next = closed_reg;
        if (cmd.load)
        begin
            len_next    = room ? (base + LW'(1)) : base;
            closed_next = last;
        end
    end

    always_comb
    begin
        p_next = p_reg;
        priority if (cmd.p_rst)
        begin
            p_next = '0;
        end
        else if (cmd.clr_step || cmd.skip || cmd.lcp_wr || (cmd.rank_step && p_lt_n))
        begin
            p_next = p_reg + LW'(1);
        end
    end

    always_comb
    begin
        k_next = k_reg;
        priority if (cmd.p_rst || cmd.skip)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + LW'(1);
        end
        else if (cmd.lcp_wr && (k_reg != '0))
        begin
            k_next = k_reg - LW'(1);
        end
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            closed_reg    <= 1'b0;
            p_reg         <= '0;
            k_reg         <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            closed_reg    <= closed_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            pv_reg        <= cmd.rank_step && p_lt_n;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[AW'(base)] <= SYMBOL_BITS'(symbol);
        end
        if (cmd.t_rd)
        begin
            ta_reg <= text_mem[AW'(pk)];
            tb_reg <= text_mem[AW'(qk)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            suf_mem[AW'(base)] <= suffix_start;
        end
        if (suf_re)
        begin
            suf_rd_reg <= suf_mem[suf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (cmd.rank_rd)
        begin
            rank_rd_reg <= rank_mem[AW'(p_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lcp_we)
        begin
            lcp_mem[lcp_waddr] <= lcp_wdata;
        end
        if (cmd.read)
        begin
            lcp_rd_reg <= lcp_mem[AW'(read_rank)];
        end
    end

    always_ff @(posedge clk)
    begin
        pd_reg <= AW'(p_reg);
        if (cmd.read)
        begin
            rr_reg  <= read_rank;
            hit_reg <= closed_reg && (WW'(read_rank) < WW'(len_reg));
        end
        if (cmd.out_load)
        begin
            out_rank_reg <= rr_reg;
            out_lcp_reg  <= hit_reg ? lcp_rd_reg : '0;
            out_vres_reg <= hit_reg;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.last_pos  = (p_reg + LW'(1)) == len_reg;
    assign stat.rank_done = (p_reg == len_reg) && !pv_reg;
    assign stat.skip      = r1 >= len_reg;
    assign stat.in_bounds = (pk < SW'(len_reg)) && (qk < SW'(len_reg));
    assign stat.match     = ta_reg == tb_reg;

    assign out_valid  = out_valid_reg;
    assign rank_index = out_rank_reg;
    assign lcp_length = out_lcp_reg;
    assign valid_res  = out_vres_reg;

    `LCPA_ASSERT(a_k_within_len, clk, rst_n, (WW'(k_reg) <= WW'(len_reg)), "match length exceeds loaded length")
    `LCPA_ASSERT_ALWAYS(a_len_within_max, clk, (!rst_n || len_reg <= LW'(MAX_LEN)), "loaded length beyond store depth")
    `LCPA_ASSERT(a_miss_reads_zero, clk, rst_n, (out_valid_reg && !out_vres_reg |-> out_lcp_reg == '0), "out-of-range read returned nonzero lcp")

endmodule

### rtl/lcp_array_from_suffix_array.sv
// LCP array builder. Load words (command 0) carry one text symbol and one suffix array
// entry each and fill position 0, 1, 2, ... at one word per clock while req.ready is
// high; the load word with last set closes the string, and a load after a closed string
// starts a new one. Closing starts the build, during which req.ready is low: a clearing
// pass over the loaded length n (one rank/lcp entry per cycle), the inverse rank pass
// (one suffix array read per cycle), then the Kasai sweep over the text positions. In the
// sweep each position reads its rank; a position that holds the last rank is skipped,
// any other reads the suffix at the next rank, then reads and compares the text at p+k
// and q+k once per matched symbol until a mismatch or the end of the string, and stores
// its lcp; the running match length drops by one per position, so matched symbols total
// at most 2n. The sweep steps through the registered read ports of the rank, suffix and
// text memories. A read word (command 1) is read into a holding register and its answer
// moves into the output register once that register is free (req.ready stays low until
// the answer has moved into it): rank_index echoes read_rank,
// lcp_length is the common prefix length with the next suffix in sorted order (0 at the
// last rank, saturated at 1023), and valid_res is 0 with lcp_length 0 when the string is
// still open or the rank is at or past the loaded length. Symbols keep their low
// SYMBOL_BITS bits; loads beyond MAX_LEN positions are dropped but still close on last.
module lcp_array_from_suffix_array #(
    parameter int MAX_LEN     = 1024,
    parameter int SYMBOL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lcpa_req_if.sink    req,
    lcpa_rsp_if.source  rsp
);
    import lcpa_pkg::*;

    lcpa_cmd_t  cmd;
    lcpa_stat_t stat;

    // sequencer: load/read handshake and build phases
    lcpa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (req.valid),
        .command (req.command),
        .last    (req.last),
        .ready   (req.ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // stores, counters, compare and output register
    lcpa_dp #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .symbol       (req.symbol),
        .suffix_start (req.suffix_start),
        .last         (req.last),
        .read_rank    (req.read_rank),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .rank_index   (rsp.rank_index),
        .lcp_length   (rsp.lcp_length),
        .valid_res    (rsp.valid_res)
    );

endmodule
